// ===== hdl/fdss_pkg.sv =====
// Shared types, constants and lookup functions for the four-digit
// seven-segment scanner. No dependencies.
`default_nettype none

package fdss_pkg;

    // Default number of scanned digits
    localparam int unsigned DIGIT_COUNT_DEF = 4;
    localparam int unsigned DIGIT_COUNT_MAX = 8;

    // Widths of the fixed payload fields
    localparam int unsigned VALUE_W = 14;
    localparam int unsigned DWELL_W = 16;
    localparam int unsigned ENABLE_W = 4;
    localparam int unsigned SEG_W = 8;
    localparam int unsigned POS_W = 2;

    // Reset value of the dwell register
    localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd1;

    // Queue between the front and back halves
    localparam int unsigned QUEUE_DEPTH = 2;

    // Scaled reciprocals of 10^k, ceil(2^31 / 10^k). Powers above the input
    // range give a zero quotient, so their entry is zero.
    localparam int unsigned RECIP_SHIFT = 31;
    localparam logic [31:0] RECIP_POW10 [DIGIT_COUNT_MAX] = '{
        32'd2147483648,
        32'd214748365,
        32'd21474837,
        32'd2147484,
        32'd214749,
        32'd0,
        32'd0,
        32'd0
    };

    // Scaled reciprocal of 10 for the back half, ceil(2^16 / 10)
    localparam int unsigned RECIP10_SHIFT = 16;
    localparam logic [12:0] RECIP10 = 13'd6554;

    // Blank pattern: all segments and decimal point off
    localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;

    // One queued item: the selected decimal quotient plus display controls
    typedef struct packed {
        logic [VALUE_W-1:0]  quot;
        logic [ENABLE_W-1:0] enable_n;
        logic [POS_W-1:0]    position;
    } t_entry;

    // 10^n, used for the clamp limit at elaboration
    function automatic int unsigned pow10(input int unsigned n);
        int unsigned p;
        p = 1;
        for (int unsigned i = 0; i < n; i++) begin
            p = p * 10;
        end
        return p;
    endfunction

    // Common-anode, active-low segment code of one decimal digit
    function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
        logic [SEG_W-1:0] code;
        unique case (digit)
            4'd0: code = 8'hC0;
            4'd1: code = 8'hF9;
            4'd2: code = 8'hA4;
            4'd3: code = 8'hB0;
            4'd4: code = 8'h99;
            4'd5: code = 8'h92;
            4'd6: code = 8'h82;
            4'd7: code = 8'hF8;
            4'd8: code = 8'h80;
            4'd9: code = 8'h90;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/fdss_front.sv =====
// Front half of the scanner: takes tick items, tracks scan position and
// dwell, clamps the value and selects the digit's quotient. Uses fdss_pkg.
`default_nettype none

module fdss_front #(
    parameter int unsigned DIGIT_COUNT = fdss_pkg::DIGIT_COUNT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // tick channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [fdss_pkg::VALUE_W-1:0]  i_shown_value,
    // dwell register write
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [fdss_pkg::DWELL_W-1:0]  i_cfg_data,
    // queue push side
    input  wire logic                          i_q_full,
    output logic                               o_q_push,
    output fdss_pkg::t_entry                   o_q_data
);
    import fdss_pkg::*;

    localparam int unsigned PW = $clog2(DIGIT_COUNT);
    localparam int unsigned LIMIT = pow10(DIGIT_COUNT) - 1;
    localparam logic [PW-1:0] POS_LAST = PW'(DIGIT_COUNT - 1);
    localparam logic [2:0] TOP_INDEX = 3'(DIGIT_COUNT - 1);

    logic [DWELL_W-1:0] r_dwell, n_dwell;
    logic [DWELL_W-1:0] r_dwell_cnt, n_dwell_cnt;
    logic [PW-1:0]      r_pos, n_pos;

    logic               accept;
    logic [VALUE_W-1:0] value_cl;
    logic [2:0]         pow_index;
    logic [45:0]        prod;
    logic [DWELL_W:0]   dwell_eff;
    logic [DWELL_W:0]   cnt_inc;
    logic [7:0]         enable_all;
    logic [2:0]         pos_ext;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_q_full;
    assign accept      = i_in_valid && !i_q_full;

    // Clamp to the largest value the digits can show
    always_comb begin
        if (32'(i_shown_value) > 32'(LIMIT)) begin
            value_cl = LIMIT[VALUE_W-1:0];
        end else begin
            value_cl = i_shown_value;
        end
    end

    // Divide by the power of ten of the lit digit
    assign pow_index = TOP_INDEX - 3'(r_pos);
    assign prod      = 46'(value_cl) * 46'(RECIP_POW10[pow_index]);

    // Drive exactly one digit low; bits above the digit count stay low
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            enable_all[i] = (i < DIGIT_COUNT) && (3'(i) != pow_index);
        end
    end

    assign pos_ext = 3'(r_pos);

    always_comb begin
        o_q_push          = accept;
        o_q_data.quot     = prod[RECIP_SHIFT +: VALUE_W];
        o_q_data.enable_n = enable_all[ENABLE_W-1:0];
        o_q_data.position = pos_ext[POS_W-1:0];
    end

    // Advance dwell and position on each accepted tick
    assign dwell_eff = (r_dwell == '0) ? 17'd1 : {1'b0, r_dwell};
    assign cnt_inc   = {1'b0, r_dwell_cnt} + 17'd1;

    always_comb begin
        n_dwell     = r_dwell;
        n_dwell_cnt = r_dwell_cnt;
        n_pos       = r_pos;
        if (i_cfg_valid) begin
            n_dwell = i_cfg_data;
        end
        if (accept) begin
            if (cnt_inc >= dwell_eff) begin
                n_dwell_cnt = '0;
                n_pos = (r_pos == POS_LAST) ? '0 : r_pos + PW'(1);
            end else begin
                n_dwell_cnt = cnt_inc[DWELL_W-1:0];
            end
        end
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dwell     <= DWELL_RESET;
            r_dwell_cnt <= '0;
            r_pos       <= '0;
        end else begin
            r_dwell     <= n_dwell;
            r_dwell_cnt <= n_dwell_cnt;
            r_pos       <= n_pos;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/fdss_queue.sv =====
// Short queue between the front and back halves of the scanner.
// Uses fdss_pkg for the entry type and depth.
`default_nettype none

module fdss_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire fdss_pkg::t_entry i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output fdss_pkg::t_entry      o_data
);
    import fdss_pkg::*;

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    t_entry        r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Advance pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/fdss_back.sv =====
// Back half of the scanner: takes queued entries, extracts the decimal
// digit, encodes segments and holds the output register. Uses fdss_pkg.
`default_nettype none

module fdss_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // queue pop side
    input  wire logic                          i_q_empty,
    input  wire fdss_pkg::t_entry              i_q_data,
    output logic                               o_q_pop,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [fdss_pkg::ENABLE_W-1:0]      o_digit_enable_n,
    output logic [fdss_pkg::SEG_W-1:0]         o_segments_n,
    output logic [fdss_pkg::POS_W-1:0]         o_digit_position
);
    import fdss_pkg::*;

    logic                r_valid;
    logic [ENABLE_W-1:0] r_enable_n;
    logic [SEG_W-1:0]    r_seg;
    logic [POS_W-1:0]    r_pos;

    logic                load;
    logic [26:0]         prod10;
    logic [10:0]         tens;
    logic [VALUE_W-1:0]  times10;
    logic [VALUE_W-1:0]  rem;

    // Take an entry whenever the output register is free or being drained
    assign load    = !i_q_empty && (!r_valid || !i_out_stall);
    assign o_q_pop = load;

    // Remainder by ten: quotient by reciprocal, then subtract ten times it
    assign prod10  = 27'(i_q_data.quot) * 27'(RECIP10);
    assign tens    = prod10[RECIP10_SHIFT +: 11];
    assign times10 = VALUE_W'({tens, 3'b000}) + VALUE_W'({tens, 1'b0});
    assign rem     = i_q_data.quot - times10;

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Output payload, held while stalled
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_enable_n <= i_q_data.enable_n;
            r_seg      <= seg_code(rem[3:0]);
            r_pos      <= i_q_data.position;
        end
    end

    assign o_out_valid      = r_valid;
    assign o_digit_enable_n = r_enable_n;
    assign o_segments_n     = r_seg;
    assign o_digit_position = r_pos;

endmodule

`default_nettype wire

// ===== hdl/four_digit_seven_segment_scanner.sv =====
// Top level of the multiplexed seven-segment scanner: front half, queue and
// back half. Depends on fdss_pkg, fdss_front, fdss_queue and fdss_back.
//
//   channel  direction  handshake              payload
//   tick     in         i_in_valid/o_in_stall  i_shown_value[13:0]
//   result   out        o_out_valid/i_out_stall o_digit_enable_n, o_segments_n,
//                                              o_digit_position
//   dwell    in         i_cfg_valid/o_cfg_ready i_cfg_data[15:0]
//
// One tick item per clock cycle while o_in_stall is low; the front multiply
// is written into the queue when the tick is taken, and digit extraction
// then loads the output register from the queue head, which holds the result.
// Synchronous active-low reset clears position, dwell count,
// queue and output valid and loads a dwell of one. A stalled result holds;
// the two-entry queue absorbs it and o_in_stall rises only when that fills.
`default_nettype none

module four_digit_seven_segment_scanner #(
    parameter int unsigned DIGIT_COUNT = fdss_pkg::DIGIT_COUNT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [fdss_pkg::VALUE_W-1:0]  i_shown_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [fdss_pkg::ENABLE_W-1:0]      o_digit_enable_n,
    output logic [fdss_pkg::SEG_W-1:0]         o_segments_n,
    output logic [fdss_pkg::POS_W-1:0]         o_digit_position,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [fdss_pkg::DWELL_W-1:0]  i_cfg_data
);
    import fdss_pkg::*;

    logic   q_full;
    logic   q_empty;
    logic   q_push;
    logic   q_pop;
    t_entry q_wdata;
    t_entry q_rdata;

    // Accept and classify ticks
    fdss_front #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_shown_value (i_shown_value),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_data      (q_wdata)
    );

    // Decouple front and back
    fdss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    // Encode and deliver results
    fdss_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .i_q_data         (q_rdata),
        .o_q_pop          (q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_digit_enable_n (o_digit_enable_n),
        .o_segments_n     (o_segments_n),
        .o_digit_position (o_digit_position)
    );

endmodule

`default_nettype wire
